// File: hw/rtl/circle_raster_symmetry_top_defines.svh
// Assertion macros shared by the circle rasterizer checkers.
// Plain text macros, no dependencies.
`ifndef CIRCLE_RASTER_SYMMETRY_TOP_DEFINES_SVH
`define CIRCLE_RASTER_SYMMETRY_TOP_DEFINES_SVH

// same-cycle implication, skipped while reset is high
`define CRS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, skipped while reset is high
`define CRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// what must hold in the cycle after reset
`define CRS_ASSERT_AFTER_RESET(lbl, clk, rst, cons, msg) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/crs_pkg.sv
// Shared types, codes and tables of the circle rasterizer.
// No dependencies; used by the controller, the datapath and the top level.
package crs_pkg;

   // result coordinates are always this wide, two's complement
   localparam int PIX_W      = 14;
   localparam int COLOR_W    = 8;
   localparam int MODE_W     = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int SLOT_W     = 3;
   localparam int COUNT_W    = 4;

   // symmetry modes; the unused code behaves as twofold
   localparam logic [MODE_W-1:0] MODE_EIGHT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FOUR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TWO   = 2'd2;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_RADIUS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COLOR  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MODE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_XMAX   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_YMAX   = 3'd4;

   // which computed coordinate feeds one axis of a mirrored pixel
   typedef enum logic [1:0] {
      SEL_X,
      SEL_Y,
      SEL_MX,
      SEL_MY
   } coord_sel_type;

   typedef struct packed {
      coord_sel_type sel_x;
      coord_sel_type sel_y;
   } pixel_pair_type;

   // controller to datapath
   typedef struct packed {
      logic              load_req;
      logic              limit_start;
      logic              limit_take;
      logic              index_fix;
      logic              square;
      logic              y_start;
      logic              y_take;
      logic              coord;
      logic              emit;
      logic              advance;
      logic [SLOT_W-1:0] slot;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic              sqrt_done;
      logic              mode_eight;
      logic [MODE_W-1:0] mode;
   } status_type;

   // pixels per column
   function automatic logic [COUNT_W-1:0] pixel_count(input logic [MODE_W-1:0] mode);
      logic [COUNT_W-1:0] n;
      priority if (mode == MODE_EIGHT) begin
         n = 4'd8;
      end else if (mode == MODE_FOUR) begin
         n = 4'd4;
      end else begin
         n = 4'd2;
      end
      return n;
   endfunction

   // emission order of the mirrored pixels within one column
   function automatic pixel_pair_type pixel_pair(input logic [MODE_W-1:0] mode,
                                                 input logic [SLOT_W-1:0] slot);
      pixel_pair_type p;
      p = '{sel_x: SEL_X, sel_y: SEL_Y};
      priority if (mode == MODE_EIGHT) begin
         unique case (slot)
            3'd0:    p = '{sel_x: SEL_X,  sel_y: SEL_Y};
            3'd1:    p = '{sel_x: SEL_Y,  sel_y: SEL_X};
            3'd2:    p = '{sel_x: SEL_Y,  sel_y: SEL_MX};
            3'd3:    p = '{sel_x: SEL_X,  sel_y: SEL_MY};
            3'd4:    p = '{sel_x: SEL_MX, sel_y: SEL_MY};
            3'd5:    p = '{sel_x: SEL_MY, sel_y: SEL_MX};
            3'd6:    p = '{sel_x: SEL_MY, sel_y: SEL_X};
            default: p = '{sel_x: SEL_MX, sel_y: SEL_Y};
         endcase
      end else if (mode == MODE_FOUR) begin
         unique case (slot[1:0])
            2'd0:    p = '{sel_x: SEL_X,  sel_y: SEL_Y};
            2'd1:    p = '{sel_x: SEL_X,  sel_y: SEL_MY};
            2'd2:    p = '{sel_x: SEL_MX, sel_y: SEL_Y};
            default: p = '{sel_x: SEL_MX, sel_y: SEL_MY};
         endcase
      end else begin
         if (slot[0]) begin
            p = '{sel_x: SEL_X, sel_y: SEL_MY};
         end else begin
            p = '{sel_x: SEL_X, sel_y: SEL_Y};
         end
      end
      return p;
   endfunction

endpackage

// File: hw/rtl/crs_req_if.sv
// Request channel of the circle rasterizer: one word per column tick.
// No dependencies.
interface crs_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

// File: hw/rtl/crs_rsp_if.sv
// Response channel of the circle rasterizer: one word per pixel.
// Depends on crs_pkg for the field widths.
interface crs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [crs_pkg::PIX_W-1:0]   pixel_x;
   logic signed [crs_pkg::PIX_W-1:0]   pixel_y;
   logic        [crs_pkg::COLOR_W-1:0] pixel_color;
   logic                               inside_res;
   logic                               last_of_column;
   logic                               last_of_circle;

   modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                   output inside_res, output last_of_column, output last_of_circle,
                   input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                   input inside_res, input last_of_column, input last_of_circle,
                   output ready);
endinterface

// File: hw/rtl/crs_isqrt.sv
// Iterative integer square root, one root bit per cycle, with remainder.
// No dependencies; instantiated by crs_datapath.
module crs_isqrt #(
   parameter int RADIUS_BITS = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [2*RADIUS_BITS+1:0]    value,
   output logic                        done,
   output logic [RADIUS_BITS:0]        root,
   output logic [RADIUS_BITS+3:0]      rem
);

   localparam int SQ_W  = 2 * RADIUS_BITS + 2;
   localparam int RT_W  = RADIUS_BITS + 1;
   localparam int REM_W = RADIUS_BITS + 4;
   localparam int CNT_W = $clog2(RT_W + 1);

   logic [SQ_W-1:0]  v_ff, v_in;
   logic [RT_W-1:0]  root_ff, root_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] count_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [REM_W-1:0] shifted;
   logic [REM_W-1:0] trial;
   logic             fits;

   // one restoring step: bring down two radicand bits, try root*4+1
   always_comb begin
      shifted = {rem_ff[REM_W-3:0], v_ff[SQ_W-1 -: 2]};
      trial   = REM_W'({root_ff, 2'b01});
      fits    = (shifted >= trial);
      rem_in  = fits ? (shifted - trial) : shifted;
      root_in = {root_ff[RT_W-2:0], fits};
      v_in    = {v_ff[SQ_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         done_ff  <= 1'b0;
         count_ff <= CNT_W'(RT_W);
      end else if (busy_ff) begin
         count_ff <= count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff    <= value;
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         v_ff    <= v_in;
         root_ff <= root_in;
         rem_ff  <= rem_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
   assign rem  = rem_ff;

endmodule

// File: hw/rtl/crs_datapath.sv
// Datapath of the circle rasterizer: registers, column state, square root,
// coordinates and the result word register. Depends on crs_pkg and crs_isqrt.
module crs_datapath #(
   parameter int RADIUS_BITS = 11,
   parameter int COORD_BITS  = 12,
   localparam int DATA_W = ((RADIUS_BITS > COORD_BITS ? RADIUS_BITS : COORD_BITS) > 8) ?
                           (RADIUS_BITS > COORD_BITS ? RADIUS_BITS : COORD_BITS) : 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [crs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]                   csr_data,
   input  logic                                req_restart,
   input  crs_pkg::cmd_type                    cmd,
   output crs_pkg::status_type                 status,
   output logic signed [crs_pkg::PIX_W-1:0]    pixel_x,
   output logic signed [crs_pkg::PIX_W-1:0]    pixel_y,
   output logic        [crs_pkg::COLOR_W-1:0]  pixel_color,
   output logic                                inside_res,
   output logic                                last_of_column,
   output logic                                last_of_circle
);

   localparam int IW    = RADIUS_BITS + 1;
   localparam int RT_W  = RADIUS_BITS + 1;
   localparam int SQ_W  = 2 * RADIUS_BITS + 2;
   localparam int RR_W  = 2 * RADIUS_BITS;
   localparam int REM_W = RADIUS_BITS + 4;
   localparam int CW    = (COORD_BITS > RADIUS_BITS ? COORD_BITS : RADIUS_BITS) + 3;
   localparam int PIX_W = crs_pkg::PIX_W;

   // configuration
   logic [RADIUS_BITS-1:0]          radius_ff;
   logic [crs_pkg::COLOR_W-1:0]     color_ff;
   logic [crs_pkg::MODE_W-1:0]      mode_ff;
   logic [COORD_BITS-1:0]           xmax_ff;
   logic [COORD_BITS-1:0]           ymax_ff;

   // column state and work registers
   logic signed [IW-1:0]            index_ff, index_in;
   logic [RADIUS_BITS-1:0]          limit_ff, limit_in;
   logic                            restart_ff;
   logic [RR_W-1:0]                 rr_ff, ii_ff;
   logic [RADIUS_BITS-1:0]          yy_ff;
   logic signed [CW-1:0]            x_ff, y_ff, mx_ff, my_ff;
   logic signed [CW-1:0]            x_in, y_in;
   logic                            final_ff;

   // result word
   logic signed [PIX_W-1:0]         px_ff, py_ff;
   logic [crs_pkg::COLOR_W-1:0]     color_out_ff;
   logic                            inside_ff, last_col_ff, last_circ_ff;

   logic                            sqrt_start;
   logic [SQ_W-1:0]                 sqrt_value;
   logic                            sqrt_done;
   logic [RT_W-1:0]                 sqrt_root;
   logic [REM_W-1:0]                sqrt_rem;

   logic                            mode_eight, mode_two;
   logic signed [IW-1:0]            start_idx, limit_s, abs_full;
   logic [RADIUS_BITS-1:0]          abs_i;
   logic [RR_W-1:0]                 rr_prod, ii_prod, diff;
   logic [RT_W:0]                   lim_sum;
   logic [RT_W-1:0]                 yy_sum;
   logic                            round_up;
   logic signed [CW-1:0]            center, xmax_s, ymax_s, px, py;
   crs_pkg::pixel_pair_type         pair;
   logic                            last_col;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
         color_ff  <= 8'd1;
         mode_ff   <= crs_pkg::MODE_EIGHT;
         xmax_ff   <= COORD_BITS'(600);
         ymax_ff   <= COORD_BITS'(600);
      end else if (csr_write_en) begin
         unique case (csr_index)
            crs_pkg::REG_RADIUS: radius_ff <= csr_data[RADIUS_BITS-1:0];
            crs_pkg::REG_COLOR:  color_ff  <= csr_data[crs_pkg::COLOR_W-1:0];
            crs_pkg::REG_MODE:   mode_ff   <= csr_data[crs_pkg::MODE_W-1:0];
            crs_pkg::REG_XMAX:   xmax_ff   <= csr_data[COORD_BITS-1:0];
            crs_pkg::REG_YMAX:   ymax_ff   <= csr_data[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // mode decode, column bounds
   always_comb begin
      mode_eight = (mode_ff == crs_pkg::MODE_EIGHT);
      mode_two   = !mode_eight && (mode_ff != crs_pkg::MODE_FOUR);
      start_idx  = mode_two ? -$signed({1'b0, radius_ff}) : '0;
      limit_s    = $signed({1'b0, limit_ff});
      lim_sum    = {1'b0, sqrt_root} + (RT_W + 1)'(1);
      limit_in   = mode_eight ? lim_sum[RADIUS_BITS:1] : radius_ff;
      // restart request or a column left out of range by a register change
      if (restart_ff || (index_ff < start_idx) || (index_ff > limit_s)) begin
         index_in = start_idx;
      end else begin
         index_in = index_ff;
      end
   end

   // squares and the root operand
   always_comb begin
      abs_full   = index_ff[IW-1] ? -index_ff : index_ff;
      abs_i      = abs_full[RADIUS_BITS-1:0];
      rr_prod    = RR_W'(radius_ff) * RR_W'(radius_ff);
      ii_prod    = RR_W'(abs_i) * RR_W'(abs_i);
      diff       = (rr_ff >= ii_ff) ? (rr_ff - ii_ff) : '0;
      sqrt_start = cmd.limit_start | cmd.y_start;
      sqrt_value = cmd.limit_start ? {1'b0, rr_ff, 1'b0} : {2'b00, diff};
      // round to nearest: step up when v - m*m exceeds m
      round_up   = (sqrt_rem > REM_W'(sqrt_root));
      yy_sum     = sqrt_root + RT_W'(round_up);
   end

   crs_isqrt #(
      .RADIUS_BITS (RADIUS_BITS)
   ) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (sqrt_value),
      .done  (sqrt_done),
      .root  (sqrt_root),
      .rem   (sqrt_rem)
   );

   // column coordinates and mirrors
   always_comb begin
      center = $signed(CW'(xmax_ff >> 1));
      xmax_s = $signed(CW'(xmax_ff));
      ymax_s = $signed(CW'(ymax_ff));
      x_in   = CW'(index_ff) + center;
      y_in   = $signed(CW'(yy_ff)) + center;
   end

   // column state
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         limit_ff <= '0;
      end else begin
         if (cmd.limit_take) begin
            limit_ff <= limit_in;
         end
         if (cmd.index_fix) begin
            index_ff <= index_in;
         end else if (cmd.advance) begin
            index_ff <= final_ff ? start_idx : (index_ff + IW'(1));
         end
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         restart_ff <= req_restart;
         rr_ff      <= rr_prod;
      end
      if (cmd.square) begin
         ii_ff <= ii_prod;
      end
      if (cmd.y_take) begin
         yy_ff <= yy_sum[RADIUS_BITS-1:0];
      end
      if (cmd.coord) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         mx_ff    <= xmax_s - x_in;
         my_ff    <= ymax_s - y_in;
         final_ff <= (index_ff >= limit_s);
      end
   end

   // pick the mirrored pair for this slot
   always_comb begin
      pair = crs_pkg::pixel_pair(mode_ff, cmd.slot);
      unique case (pair.sel_x)
         crs_pkg::SEL_X:  px = x_ff;
         crs_pkg::SEL_Y:  px = y_ff;
         crs_pkg::SEL_MX: px = mx_ff;
         default:         px = my_ff;
      endcase
      unique case (pair.sel_y)
         crs_pkg::SEL_X:  py = x_ff;
         crs_pkg::SEL_Y:  py = y_ff;
         crs_pkg::SEL_MX: py = mx_ff;
         default:         py = my_ff;
      endcase
      last_col = ({1'b0, cmd.slot} == (crs_pkg::pixel_count(mode_ff) - 4'd1));
   end

   // result word register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         px_ff        <= px[PIX_W-1:0];
         py_ff        <= py[PIX_W-1:0];
         color_out_ff <= color_ff;
         inside_ff    <= (px >= 0) && (px <= xmax_s) && (py >= 0) && (py <= ymax_s);
         last_col_ff  <= last_col;
         last_circ_ff <= last_col && final_ff;
      end
   end

   assign status.sqrt_done  = sqrt_done;
   assign status.mode_eight = mode_eight;
   assign status.mode       = mode_ff;

   assign pixel_x        = px_ff;
   assign pixel_y        = py_ff;
   assign pixel_color    = color_out_ff;
   assign inside_res     = inside_ff;
   assign last_of_column = last_col_ff;
   assign last_of_circle = last_circ_ff;

endmodule

// File: hw/rtl/crs_ctrl.sv
// Controller of the circle rasterizer: sequences one column per request word
// and owns both handshakes. Depends on crs_pkg.
module crs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  crs_pkg::status_type status,
   output crs_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_LIMIT_WAIT,
      ST_INDEX,
      ST_SQUARE,
      ST_Y_START,
      ST_Y_WAIT,
      ST_COORD,
      ST_EMIT
   } state_type;

   state_type                      state_ff, state_in;
   logic [crs_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           out_free;
   logic                           slot_last;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      slot_last    = ({1'b0, slot_ff} == (crs_pkg::pixel_count(status.mode) - 4'd1));
      cmd          = '0;
      cmd.slot     = slot_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_LIMIT;
            end
         end
         ST_LIMIT: begin
            // only eightfold needs a root for its last column
            if (status.mode_eight) begin
               cmd.limit_start = 1'b1;
               state_in        = ST_LIMIT_WAIT;
            end else begin
               cmd.limit_take = 1'b1;
               state_in       = ST_INDEX;
            end
         end
         ST_LIMIT_WAIT: begin
            if (status.sqrt_done) begin
               cmd.limit_take = 1'b1;
               state_in       = ST_INDEX;
            end
         end
         ST_INDEX: begin
            cmd.index_fix = 1'b1;
            state_in      = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_Y_START;
         end
         ST_Y_START: begin
            cmd.y_start = 1'b1;
            state_in    = ST_Y_WAIT;
         end
         ST_Y_WAIT: begin
            if (status.sqrt_done) begin
               cmd.y_take = 1'b1;
               state_in   = ST_COORD;
            end
         end
         ST_COORD: begin
            cmd.coord = 1'b1;
            slot_in   = '0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            // one pixel into the result register whenever it frees up
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               slot_in      = slot_ff + crs_pkg::SLOT_W'(1);
               if (slot_last) begin
                  cmd.advance = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/circle_raster_symmetry_top.sv
// Circle rasterizer, one column per request word. Each request word either
// restarts at the first column of the current symmetry mode or advances one
// column, wrapping to the first column after the last; the block answers with
// 8, 4 or 2 mirrored pixel words (eightfold, fourfold, twofold). The square
// roots come from one shared unit that yields one root bit per cycle, and the
// pixel words leave one per cycle, while the receiver is ready, through a
// single result register. Eightfold mode takes two roots per column (the last
// column and the height), the other modes only the height. The next request
// word is taken once the last pixel of a column sits in the result register.
// Registers are written through the csr_ port while the block idles; the user
// is bound to this, the block itself does not enforce it.
// Depends on crs_pkg, crs_req_if, crs_rsp_if, crs_ctrl and crs_datapath.
module circle_raster_symmetry_top #(
   parameter int RADIUS_BITS = 11,
   parameter int COORD_BITS  = 12,
   localparam int DATA_W = ((RADIUS_BITS > COORD_BITS ? RADIUS_BITS : COORD_BITS) > 8) ?
                           (RADIUS_BITS > COORD_BITS ? RADIUS_BITS : COORD_BITS) : 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [crs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]               csr_data,
   crs_req_if.sink                         req_bus,
   crs_rsp_if.source                       rsp_bus
);

   crs_pkg::cmd_type    cmd;
   crs_pkg::status_type status;

   crs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   crs_datapath #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_restart    (req_bus.restart),
      .cmd            (cmd),
      .status         (status),
      .pixel_x        (rsp_bus.pixel_x),
      .pixel_y        (rsp_bus.pixel_y),
      .pixel_color    (rsp_bus.pixel_color),
      .inside_res     (rsp_bus.inside_res),
      .last_of_column (rsp_bus.last_of_column),
      .last_of_circle (rsp_bus.last_of_circle)
   );

endmodule

// File: hw/rtl/crs_checker.sv
// Port-level checks of the circle rasterizer, bound to the top level.
// Depends on crs_pkg and circle_raster_symmetry_top_defines.svh.
`include "circle_raster_symmetry_top_defines.svh"

module crs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [crs_pkg::PIX_W-1:0]  rsp_pixel_x,
   input logic signed [crs_pkg::PIX_W-1:0]  rsp_pixel_y,
   input logic                              rsp_last_of_column,
   input logic                              rsp_last_of_circle
);

   // a stalled pixel word holds
   `CRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y) && $stable(rsp_last_of_column), "stalled pixel word changed")

   // the circle only ends on the last pixel of a column
   `CRS_ASSERT_SAME(a_circle_ends_column, clock, reset, rsp_valid && rsp_last_of_circle, rsp_last_of_column, "last_of_circle without last_of_column")

   // no request word is taken while a column is still being emitted
   `CRS_ASSERT_SAME(a_busy_mid_column, clock, reset, rsp_valid && !rsp_last_of_column, !req_ready, "request taken in the middle of a column")

   // nothing is offered right after reset
   `CRS_ASSERT_AFTER_RESET(a_reset_quiet, clock, reset, !rsp_valid, "pixel word valid after reset")

endmodule

bind circle_raster_symmetry_top crs_checker u_crs_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_pixel_x        (rsp_bus.pixel_x),
   .rsp_pixel_y        (rsp_bus.pixel_y),
   .rsp_last_of_column (rsp_bus.last_of_column),
   .rsp_last_of_circle (rsp_bus.last_of_circle)
);

// File: tb/tb_circle_raster_symmetry_top.sv
// Self-checking testbench of circle_raster_symmetry_top: column words go in, and each
// pixel word that comes out is checked against a predictor of the mirrored circle.
// Depends on crs_pkg, crs_req_if, crs_rsp_if and the circle_raster_symmetry_top RTL.
module tb_circle_raster_symmetry_top;

   localparam int RADIUS_BITS = 11;
   localparam int COORD_BITS  = 12;
   localparam int CSR_W       = 12;
   // the unused mode code, which behaves as twofold
   localparam logic [crs_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 60;

   typedef struct packed {
      logic signed [crs_pkg::PIX_W-1:0] x;
      logic signed [crs_pkg::PIX_W-1:0] y;
      logic [crs_pkg::COLOR_W-1:0]      color;
      logic                             in_view;
      logic                             last_col;
      logic                             last_circ;
   } pixel_word_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_write_en;
   logic [crs_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [CSR_W-1:0]                csr_data;

   crs_req_if req_bus ();
   crs_rsp_if rsp_bus ();

   circle_raster_symmetry_top #(
      .RADIUS_BITS(RADIUS_BITS),
      .COORD_BITS (COORD_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   // shadow registers and column counter of the predictor
   logic [RADIUS_BITS-1:0]      radius_cfg;
   logic [crs_pkg::COLOR_W-1:0] color_cfg;
   logic [crs_pkg::MODE_W-1:0]  mode_cfg;
   logic [COORD_BITS-1:0]       xmax_cfg;
   logic [COORD_BITS-1:0]       ymax_cfg;
   longint                      column_idx;

   pixel_word_type pixel_q[$];
   int errors        = 0;
   int items_sent    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int rsp_hold_len  = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // floor of the square root, one result bit per pass
   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root, bitv, rem;
      root = 0;
      rem  = v;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  -= root + bitv;
            root  = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // square root rounded to nearest; a tie cannot occur for integers
   function automatic longint unsigned nearest_root(input longint unsigned v);
      longint unsigned m;
      m = floor_root(v);
      return (v - m * m > m) ? m + 1 : m;
   endfunction

   function automatic longint last_column();
      longint rad;
      rad = longint'(radius_cfg);
      if (mode_cfg == crs_pkg::MODE_EIGHT) begin
         return longint'((floor_root(2 * rad * rad) + 1) >> 1);
      end
      return rad;
   endfunction

   function automatic longint first_column();
      return (mode_cfg >= crs_pkg::MODE_TWO) ? -longint'(radius_cfg) : 0;
   endfunction

   // one column word: queue its mirrored pixels and step the column counter
   function automatic void predict_column(input logic restart);
      longint         rad, first, lim, i, mag, h, c, x, y, mx, my;
      longint         px[8];
      longint         py[8];
      int             n;
      pixel_word_type w;
      rad   = longint'(radius_cfg);
      first = first_column();
      lim   = last_column();
      if (restart || column_idx < first || column_idx > lim) column_idx = first;
      i   = column_idx;
      mag = (i < 0) ? -i : i;
      h   = (mag > rad) ? 0 : longint'(nearest_root(rad * rad - mag * mag));
      c   = longint'(xmax_cfg >> 1);
      x   = i + c;
      y   = h + c;
      mx  = longint'(xmax_cfg) - x;
      my  = longint'(ymax_cfg) - y;
      if (mode_cfg == crs_pkg::MODE_EIGHT) begin
         n  = 8;
         px = '{x, y, y,  x,  mx, my, my, mx};
         py = '{y, x, mx, my, my, mx, x,  y};
      end else if (mode_cfg == crs_pkg::MODE_FOUR) begin
         n  = 4;
         px = '{x, x,  mx, mx, 0, 0, 0, 0};
         py = '{y, my, y,  my, 0, 0, 0, 0};
      end else begin
         n  = 2;
         px = '{x, x,  0, 0, 0, 0, 0, 0};
         py = '{y, my, 0, 0, 0, 0, 0, 0};
      end
      for (int k = 0; k < n; k++) begin
         w.x         = px[k][crs_pkg::PIX_W-1:0];
         w.y         = py[k][crs_pkg::PIX_W-1:0];
         w.color     = color_cfg;
         w.in_view   = px[k] >= 0 && px[k] <= longint'(xmax_cfg) &&
                       py[k] >= 0 && py[k] <= longint'(ymax_cfg);
         w.last_col  = (k == n - 1);
         w.last_circ = (k == n - 1) && (i >= lim);
         pixel_q.push_back(w);
      end
      column_idx = (i >= lim) ? first : i + 1;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic compare_field(input string field, input longint want, input longint got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // accepted words on both channels, plus the watchdog
   always @(posedge clock) begin
      pixel_word_type got, want;
      logic           moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predict_column(req_bus.restart);
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            got = '{x: rsp_bus.pixel_x, y: rsp_bus.pixel_y, color: rsp_bus.pixel_color,
                    in_view: rsp_bus.inside_res, last_col: rsp_bus.last_of_column,
                    last_circ: rsp_bus.last_of_circle};
            if (pixel_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected pixel word, expected none, actual x=%0d y=%0d",
                        $time, got.x, got.y);
            end else begin
               want = pixel_q.pop_front();
               compare_field("pixel_x", want.x, got.x);
               compare_field("pixel_y", want.y, got.y);
               compare_field("pixel_color", want.color, got.color);
               compare_field("inside_res", want.in_view, got.in_view);
               compare_field("last_of_column", want.last_col, got.last_col);
               compare_field("last_of_circle", want.last_circ, got.last_circ);
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("circle_raster_symmetry_top test failed");
            $finish;
         end
      end
   end

   // receiver: random stalls, or a long hold when one is requested
   always @(negedge clock) begin
      if (rsp_hold_len > 0) begin
         hold_left    = rsp_hold_len;
         rsp_hold_len = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- driving

   task automatic send_word(input logic restart);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid   <= 1'b0;
         req_bus.restart <= 1'($urandom_range(1));
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.restart <= restart;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   // stop offering and wait until every queued pixel has come back
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pixel_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [crs_pkg::CSR_INDEX_W-1:0] index, input int value);
      wait_drained();
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_data     <= value[CSR_W-1:0];
      case (index)
         crs_pkg::REG_RADIUS: radius_cfg = value[RADIUS_BITS-1:0];
         crs_pkg::REG_COLOR:  color_cfg  = value[crs_pkg::COLOR_W-1:0];
         crs_pkg::REG_MODE:   mode_cfg   = value[crs_pkg::MODE_W-1:0];
         crs_pkg::REG_XMAX:   xmax_cfg   = value[COORD_BITS-1:0];
         crs_pkg::REG_YMAX:   ymax_cfg   = value[COORD_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_circle(input int rad, input int colr,
                             input logic [crs_pkg::MODE_W-1:0] mode,
                             input int xmax, input int ymax);
      write_reg(crs_pkg::REG_RADIUS, rad);
      write_reg(crs_pkg::REG_COLOR, colr);
      write_reg(crs_pkg::REG_MODE, mode);
      write_reg(crs_pkg::REG_XMAX, xmax);
      write_reg(crs_pkg::REG_YMAX, ymax);
   endtask

   // ---------------------------------------------------------------- tests

   // reset state: zero radius, so every column is the whole circle
   task automatic test_reset_state();
      send_word(1'b0);
      send_word(1'b1);
   endtask

   // every symmetry mode, including the spare code, with a wrap at the end
   task automatic test_each_mode();
      write_reg(crs_pkg::REG_RADIUS, 1);
      write_reg(crs_pkg::REG_COLOR, 255);
      write_reg(crs_pkg::REG_MODE, crs_pkg::MODE_EIGHT);
      send_word(1'b1); send_word(1'b0); send_word(1'b0);
      write_reg(crs_pkg::REG_MODE, crs_pkg::MODE_FOUR);
      send_word(1'b1); send_word(1'b0);
      write_reg(crs_pkg::REG_MODE, crs_pkg::MODE_TWO);
      send_word(1'b1); send_word(1'b0); send_word(1'b0);
      write_reg(crs_pkg::REG_MODE, MODE_SPARE);
      send_word(1'b1); send_word(1'b0); send_word(1'b0);
   endtask

   // largest radius and viewport, zero color
   task automatic test_extremes();
      set_circle(2047, 0, crs_pkg::MODE_FOUR, 4095, 4095);
      send_word(1'b1);
      send_word(1'b0);
      write_reg(crs_pkg::REG_MODE, crs_pkg::MODE_EIGHT);
      send_word(1'b1);
   endtask

   // viewport of zero size: center at the origin, pixels still computed
   task automatic test_zero_viewport();
      set_circle(5, 8'h3C, crs_pkg::MODE_EIGHT, 0, 0);
      send_word(1'b1);
   endtask

   // shrinking the radius past the index restarts it; a mode change keeps it
   task automatic test_stale_index();
      set_circle(5, 8'h5A, crs_pkg::MODE_FOUR, 12, 9);
      send_word(1'b1); send_word(1'b0); send_word(1'b0);
      write_reg(crs_pkg::REG_RADIUS, 2);
      send_word(1'b0);
      write_reg(crs_pkg::REG_MODE, crs_pkg::MODE_EIGHT);
      send_word(1'b0);
   endtask

   // receiver holds off while the sender keeps offering, then the sender pauses
   task automatic test_backpressure();
      int saved;
      saved = send_idle_pct;
      send_idle_pct = 0;
      set_circle(9, 8'hA5, crs_pkg::MODE_EIGHT, 20, 20);
      send_word(1'b1);
      rsp_hold_len = HOLD_CYCLES;
      repeat (6) send_word(1'b0);
      wait_drained();
      repeat (3) send_word(1'b0);
      send_idle_pct = saved;
   endtask

   // viewport edge: extremes, anything, or near the circle's size
   function automatic int pick_extent(input int rad);
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 0;
      if (pick == 1) return 4095;
      if (pick < 6) return $urandom_range(1, 4095);
      return $urandom_range(0, (2 * rad + 4 > 4095) ? 4095 : 2 * rad + 4);
   endfunction

   // new settings; some registers kept so that the index may carry over
   task automatic random_setup();
      int pick, rad;
      pick = $urandom_range(99);
      rad = (pick < 80) ? $urandom_range(0, 12) :
            (pick < 95) ? $urandom_range(13, 300) : $urandom_range(1000, 2047);
      write_reg(crs_pkg::REG_RADIUS, rad);
      if ($urandom_range(3) != 0) write_reg(crs_pkg::REG_MODE, $urandom_range(0, 3));
      if ($urandom_range(1) != 0) write_reg(crs_pkg::REG_COLOR, $urandom_range(0, 255));
      if ($urandom_range(3) != 0) write_reg(crs_pkg::REG_XMAX, pick_extent(rad));
      if ($urandom_range(3) != 0) write_reg(crs_pkg::REG_YMAX, pick_extent(rad));
   endtask

   // random circles: mostly a restart and then a sweep, a full one for small circles, with stray restarts
   task automatic run_random_circles(input int send_pct, input int recv_pct, input int count);
      int target, span, n, pick;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      target = items_sent + count;
      while (items_sent < target) begin
         random_setup();
         span = int'(last_column() - first_column() + 1);
         n = (span < 20) ? span + $urandom_range(0, 2) : $urandom_range(4, 20);
         for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            send_word((k == 0) ? (pick < 90) : (pick < 4));
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = crs_pkg::REG_RADIUS;
      csr_data        = '0;
      req_bus.valid   = 1'b0;
      req_bus.restart = 1'b0;
      rsp_bus.ready   = 1'b0;
      radius_cfg      = '0;
      color_cfg       = 8'd1;
      mode_cfg        = crs_pkg::MODE_EIGHT;
      xmax_cfg        = 12'd600;
      ymax_cfg        = 12'd600;
      column_idx      = 0;
      send_idle_pct   = 33;
      recv_idle_pct   = 83;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_each_mode();
      test_extremes();
      test_zero_viewport();
      test_stale_index();
      test_backpressure();
      run_random_circles(33, 83, 140);
      run_random_circles(83, 33, 140);
      run_random_circles(0, 0, 125);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("circle_raster_symmetry_top test passed");
      end else begin
         $display("circle_raster_symmetry_top test failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/crs_pkg.sv
hw/rtl/crs_req_if.sv
hw/rtl/crs_rsp_if.sv
hw/rtl/crs_isqrt.sv
hw/rtl/crs_datapath.sv
hw/rtl/crs_ctrl.sv
hw/rtl/circle_raster_symmetry_top.sv
hw/rtl/crs_checker.sv
tb/tb_circle_raster_symmetry_top.sv
